@@ rtl/core/plst_pkg.sv @@
package plst_pkg;

  localparam int HOST_COUNT = 64;
  localparam int COUNT_BITS = 24;

  localparam int HOST_AW    = (HOST_COUNT > 1) ? $clog2(HOST_COUNT) : 1;
  localparam int HOST_W     = 6;
  localparam int LAT_W      = 20;
  localparam int MISS_W     = 16;
  localparam int SUM_W      = 44;
  localparam int SQ_W       = 64;
  localparam int OUT_W      = 20;
  localparam int TOT_W      = 24;
  localparam int DROP_W     = 17;
  localparam int DROP_FRAC  = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_W      = (SUM_W > COUNT_BITS) ? SUM_W : COUNT_BITS;
  localparam int PROD_W     = (COUNT_BITS + SQ_W > 2 * SUM_W) ? COUNT_BITS + SQ_W : 2 * SUM_W;
  localparam int DEN_W      = 2 * COUNT_BITS;
  localparam int SQRT_W     = 2 * OUT_W;
  localparam int SQRT_STEPS = OUT_W;
  localparam int CNT_W      = $clog2(PROD_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_RESOLVE_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_THRESHOLD = CFG_IDX_W'(1);

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [HOST_W-1:0] host_index;
    logic              answered;
    logic [LAT_W-1:0]  latency_us;
  } in_item_t;

  typedef struct packed {
    logic [HOST_W-1:0] host_echo;
    logic              resolve_request;
    logic              has_probes;
    logic              has_replies;
    logic [TOT_W-1:0]  sent_total;
    logic [TOT_W-1:0]  received_total;
    logic [OUT_W-1:0]  mean_latency;
    logic [OUT_W-1:0]  stddev_latency;
    logic [DROP_W-1:0] drop_rate;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] sent;
    logic [COUNT_BITS-1:0] recv;
    logic [MISS_W-1:0]     miss;
    logic [SUM_W-1:0]      sum;
    logic [SQ_W-1:0]       sq;
  } entry_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] sent;
    logic [COUNT_BITS-1:0] n;
    logic [SUM_W-1:0]      sum;
    logic [SQ_W-1:0]       sq;
  } rpt_args_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] sent;
    logic [COUNT_BITS-1:0] n;
    logic [OUT_W-1:0]      mean;
    logic [OUT_W-1:0]      stddev;
    logic [DROP_W-1:0]     drop;
  } rpt_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_CALC
  } top_state_e;

  typedef enum logic [3:0] {
    RS_IDLE,
    RS_MUL_SQ,
    RS_MUL_SUM,
    RS_MUL_DEN,
    RS_DIV_VAR,
    RS_SQRT,
    RS_DIV_MEAN,
    RS_DIV_DROP,
    RS_DONE
  } rpt_state_e;

endpackage

@@ rtl/core/plst_table.sv @@
module plst_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [plst_pkg::HOST_AW-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [plst_pkg::HOST_AW-1:0] wr_addr_i,
  input  plst_pkg::entry_t             wr_data_i,
  output plst_pkg::entry_t             rd_data_o
);

  plst_pkg::entry_t                     mem_q [plst_pkg::HOST_COUNT];
  plst_pkg::entry_t                     rdata_q;
  logic [plst_pkg::HOST_COUNT-1:0]      vld_q;
  logic                                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // entries never written read as zero
  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/core/plst_report.sv @@
module plst_report (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  plst_pkg::rpt_args_t args_i,
  input  logic                ack_i,
  output logic                done_o,
  output plst_pkg::rpt_res_t  res_o
);

  localparam int PW = plst_pkg::PROD_W;
  localparam int DW = plst_pkg::DEN_W;
  localparam int SW = plst_pkg::SQRT_W;
  localparam int CW = plst_pkg::COUNT_BITS;
  localparam int OW = plst_pkg::OUT_W;

  plst_pkg::rpt_state_e state_q, state_d;

  logic [plst_pkg::CNT_W-1:0]  cnt_q;
  logic [CW-1:0]               n_q, sent_q;
  logic [plst_pkg::SUM_W-1:0]  sum_q;
  logic [PW-1:0]               a_q, p_q, prod_sq_q, prod_sum_q;
  logic [plst_pkg::MUL_W-1:0]  b_q;
  logic [PW-1:0]               dvd_q, quo_q;
  logic [DW-1:0]               rem_q, dvs_q;
  logic [SW-1:0]               v_q, res_q, bit_q;
  logic                        big_q;
  logic [OW-1:0]               sd_q, mean_q;
  logic [plst_pkg::DROP_W-1:0] drop_q;

  logic [PW-1:0] p_step;
  logic [DW:0]   rem_sh;
  logic          rem_ge;
  logic [DW-1:0] rem_nx;
  logic [PW-1:0] quo_nx;
  logic [SW-1:0] sq_try, res_nx;
  logic          sq_ge;
  logic          mul_last, div_last, sqrt_last;

  assign p_step    = b_q[0] ? p_q + a_q : p_q;
  assign rem_sh    = {rem_q, dvd_q[PW-1]};
  assign rem_ge    = rem_sh >= {1'b0, dvs_q};
  assign rem_nx    = rem_ge ? DW'(rem_sh - {1'b0, dvs_q}) : DW'(rem_sh);
  assign quo_nx    = {quo_q[PW-2:0], rem_ge};
  assign sq_try    = res_q + bit_q;
  assign sq_ge     = v_q >= sq_try;
  assign res_nx    = sq_ge ? (res_q >> 1) + bit_q : (res_q >> 1);
  assign mul_last  = cnt_q == plst_pkg::CNT_W'(plst_pkg::MUL_W - 1);
  assign div_last  = cnt_q == plst_pkg::CNT_W'(PW - 1);
  assign sqrt_last = cnt_q == plst_pkg::CNT_W'(plst_pkg::SQRT_STEPS - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plst_pkg::RS_IDLE:     if (start_i)  state_d = plst_pkg::RS_MUL_SQ;
      plst_pkg::RS_MUL_SQ:   if (mul_last) state_d = plst_pkg::RS_MUL_SUM;
      plst_pkg::RS_MUL_SUM:  if (mul_last) state_d = plst_pkg::RS_MUL_DEN;
      plst_pkg::RS_MUL_DEN:  if (mul_last) state_d = plst_pkg::RS_DIV_VAR;
      plst_pkg::RS_DIV_VAR:  if (div_last) state_d = plst_pkg::RS_SQRT;
      plst_pkg::RS_SQRT:     if (sqrt_last) state_d = plst_pkg::RS_DIV_MEAN;
      plst_pkg::RS_DIV_MEAN: if (div_last) state_d = plst_pkg::RS_DIV_DROP;
      plst_pkg::RS_DIV_DROP: if (div_last) state_d = plst_pkg::RS_DONE;
      plst_pkg::RS_DONE:     if (ack_i)    state_d = plst_pkg::RS_IDLE;
      default:               state_d = plst_pkg::RS_IDLE;
    endcase
  end

  always_comb begin
    done_o      = state_q == plst_pkg::RS_DONE;
    res_o.sent   = sent_q;
    res_o.n      = n_q;
    res_o.mean   = mean_q;
    res_o.stddev = sd_q;
    res_o.drop   = drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plst_pkg::RS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q != state_d) ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      plst_pkg::RS_IDLE: begin
        if (start_i) begin
          n_q    <= args_i.n;
          sent_q <= args_i.sent;
          sum_q  <= args_i.sum;
          a_q    <= PW'(args_i.sq);
          b_q    <= plst_pkg::MUL_W'(args_i.n);
          p_q    <= '0;
        end
      end
      plst_pkg::RS_MUL_SQ, plst_pkg::RS_MUL_SUM, plst_pkg::RS_MUL_DEN: begin
        if (mul_last) begin
          p_q <= '0;
          if (state_q == plst_pkg::RS_MUL_SQ) begin
            prod_sq_q <= p_step;
            a_q       <= PW'(sum_q);
            b_q       <= plst_pkg::MUL_W'(sum_q);
          end else if (state_q == plst_pkg::RS_MUL_SUM) begin
            prod_sum_q <= p_step;
            a_q        <= PW'(n_q - CW'(1));
            b_q        <= plst_pkg::MUL_W'(n_q);
          end else begin
            // variance numerator, negative only after saturation
            dvs_q <= DW'(p_step);
            dvd_q <= (prod_sq_q > prod_sum_q) ? prod_sq_q - prod_sum_q : '0;
            rem_q <= '0;
            quo_q <= '0;
          end
        end else begin
          p_q <= p_step;
          a_q <= a_q << 1;
          b_q <= b_q >> 1;
        end
      end
      plst_pkg::RS_DIV_VAR, plst_pkg::RS_DIV_MEAN, plst_pkg::RS_DIV_DROP: begin
        if (div_last) begin
          rem_q <= '0;
          quo_q <= '0;
          if (state_q == plst_pkg::RS_DIV_VAR) begin
            big_q <= |quo_nx[PW-1:SW];
            v_q   <= quo_nx[SW-1:0];
            res_q <= '0;
            bit_q <= SW'(1) << (SW - 2);
          end else if (state_q == plst_pkg::RS_DIV_MEAN) begin
            mean_q <= (|quo_nx[PW-1:OW]) ? '1 : quo_nx[OW-1:0];
            dvd_q  <= PW'({sent_q - n_q, plst_pkg::DROP_FRAC'(0)});
            dvs_q  <= DW'(sent_q);
          end else begin
            drop_q <= quo_nx[plst_pkg::DROP_W-1:0];
          end
        end else begin
          dvd_q <= dvd_q << 1;
          rem_q <= rem_nx;
          quo_q <= quo_nx;
        end
      end
      plst_pkg::RS_SQRT: begin
        if (sq_ge) begin
          v_q <= v_q - sq_try;
        end
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        if (sqrt_last) begin
          sd_q  <= big_q ? '1 : res_nx[OW-1:0];
          dvd_q <= PW'(sum_q);
          dvs_q <= DW'(n_q);
        end
      end
      plst_pkg::RS_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/ping_latency_stats_table.sv @@
// a record reads its table entry, then writes it back (valid hosts) and registers its result
// when the output is free; a new item is accepted only in ST_IDLE, after the last one
// a report runs three products on the shared shift-add multiplier, then the
// restoring divider for the variance, the square-root unit, and the divider
// again for the mean and the drop rate
// reset: asynchronous active low, per-entry valid bits make the table read zero
module ping_latency_stats_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  plst_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output plst_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [plst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [plst_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = plst_pkg::COUNT_BITS;

  plst_pkg::top_state_e state_q, state_d;
  plst_pkg::in_item_t   item_q;
  logic [2*plst_pkg::LAT_W-1:0] sqlat_q;
  logic                       en_q;
  logic [plst_pkg::MISS_W-1:0] thr_q;
  logic                       out_valid_q;
  plst_pkg::out_item_t        out_q, out_d;

  plst_pkg::entry_t    rd_e, wr_e, rec_e;
  plst_pkg::rpt_args_t args;
  plst_pkg::rpt_res_t  res;
  logic                rpt_done;

  logic in_acc, out_free, host_ok, is_rpt, rpt_calc;
  logic out_load, wr_en, rpt_start, rpt_ack;
  logic rec_req;
  logic [plst_pkg::SUM_W:0]  sum_w;
  logic [plst_pkg::SQ_W:0]   sq_w;
  logic [plst_pkg::MISS_W-1:0] miss_nx;
  logic [CW-1:0]             n_eff;

  assign in_ready_o  = state_q == plst_pkg::ST_IDLE;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign host_ok     = 32'(item_q.host_index) < plst_pkg::HOST_COUNT;
  assign is_rpt      = item_q.kind == plst_pkg::KIND_REPORT;
  assign rpt_calc    = is_rpt && host_ok && (rd_e.sent != '0);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  plst_table u_table (
    .clk_i,
    .rst_ni,
    .rd_en_i   (in_acc),
    .rd_addr_i (plst_pkg::HOST_AW'(in_data_i.host_index)),
    .wr_en_i   (wr_en),
    .wr_addr_i (plst_pkg::HOST_AW'(item_q.host_index)),
    .wr_data_i (wr_e),
    .rd_data_o (rd_e)
  );

  plst_report u_report (
    .clk_i,
    .rst_ni,
    .start_i (rpt_start),
    .args_i  (args),
    .ack_i   (rpt_ack),
    .done_o  (rpt_done),
    .res_o   (res)
  );

  always_comb begin
    rec_e      = rd_e;
    rec_e.sent = (rd_e.sent == '1) ? rd_e.sent : rd_e.sent + CW'(1);
    sum_w      = {1'b0, rd_e.sum} + (plst_pkg::SUM_W + 1)'(item_q.latency_us);
    sq_w       = {1'b0, rd_e.sq} + (plst_pkg::SQ_W + 1)'(sqlat_q);
    miss_nx    = (rd_e.miss == '1) ? rd_e.miss : rd_e.miss + plst_pkg::MISS_W'(1);
    if (item_q.answered) begin
      rec_e.recv = (rd_e.recv == '1) ? rd_e.recv : rd_e.recv + CW'(1);
      rec_e.sum  = sum_w[plst_pkg::SUM_W] ? '1 : sum_w[plst_pkg::SUM_W-1:0];
      rec_e.sq   = sq_w[plst_pkg::SQ_W] ? '1 : sq_w[plst_pkg::SQ_W-1:0];
      rec_e.miss = '0;
    end else begin
      rec_e.miss = miss_nx;
    end
    rec_req = en_q && (rec_e.miss >= thr_q);
    if (rec_req) begin
      rec_e.miss = '0;
    end

    n_eff     = (rd_e.recv > rd_e.sent) ? rd_e.sent : rd_e.recv;
    args.sent = rd_e.sent;
    args.n    = n_eff;
    args.sum  = rd_e.sum;
    args.sq   = rd_e.sq;

    if (is_rpt) begin
      wr_e      = '0;
      wr_e.miss = rd_e.miss;
    end else begin
      wr_e = rec_e;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plst_pkg::ST_IDLE: begin
        if (in_acc) state_d = plst_pkg::ST_ACCESS;
      end
      plst_pkg::ST_ACCESS: begin
        if (rpt_calc) state_d = plst_pkg::ST_CALC;
        else if (out_free) state_d = plst_pkg::ST_IDLE;
      end
      plst_pkg::ST_CALC: begin
        if (rpt_done && out_free) state_d = plst_pkg::ST_IDLE;
      end
      default: state_d = plst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_load  = 1'b0;
    wr_en     = 1'b0;
    rpt_start = 1'b0;
    rpt_ack   = 1'b0;
    out_d     = '0;
    out_d.host_echo = item_q.host_index;
    unique case (state_q)
      plst_pkg::ST_IDLE: begin
      end
      plst_pkg::ST_ACCESS: begin
        rpt_start = rpt_calc;
        out_load  = !rpt_calc && out_free;
        wr_en     = host_ok && (rpt_calc || out_free);
        out_d.resolve_request = !is_rpt && host_ok && rec_req;
      end
      plst_pkg::ST_CALC: begin
        rpt_ack  = rpt_done && out_free;
        out_load = rpt_ack;
        out_d.has_probes     = 1'b1;
        out_d.has_replies    = res.n != '0;
        out_d.sent_total     = plst_pkg::TOT_W'(res.sent);
        out_d.received_total = plst_pkg::TOT_W'(res.n);
        out_d.drop_rate      = res.drop;
        out_d.mean_latency   = (res.n != '0) ? res.mean : '0;
        out_d.stddev_latency = (res.n >= CW'(2)) ? res.stddev : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      en_q        <= 1'b0;
      thr_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          plst_pkg::CFG_RESOLVE_ENABLE: en_q  <= cfg_data_i[0];
          plst_pkg::CFG_MISS_THRESHOLD: thr_q <= cfg_data_i[plst_pkg::MISS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q  <= in_data_i;
      sqlat_q <= in_data_i.latency_us * in_data_i.latency_us;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule

@@ rtl/core/plst_checker.sv @@
module plst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input plst_pkg::out_item_t out_data_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  a_replies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_replies |-> out_data_o.has_probes)
    else $error("replies without probes");

  a_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.resolve_request |-> !out_data_o.has_probes)
    else $error("resolve request on a report");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_probes |->
      out_data_o.sent_total == '0 && out_data_o.drop_rate == '0 &&
      out_data_o.mean_latency == '0 && out_data_o.stddev_latency == '0)
    else $error("statistics without probes");

endmodule

bind ping_latency_stats_table plst_checker u_plst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ bench/ping_latency_stats_table_tb.sv @@
module ping_latency_stats_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HC    = plst_pkg::HOST_COUNT;
  localparam int CB    = plst_pkg::COUNT_BITS;
  localparam int MW    = plst_pkg::MISS_W;
  localparam int SMW   = plst_pkg::SUM_W;
  localparam int QW    = plst_pkg::SQ_W;
  localparam int OW    = plst_pkg::OUT_W;
  localparam int IXW   = plst_pkg::CFG_IDX_W;
  localparam int DTW   = plst_pkg::CFG_DATA_W;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  plst_pkg::in_item_t        in_data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  plst_pkg::out_item_t       out_data_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [IXW-1:0]            cfg_index_i;
  logic [DTW-1:0]            cfg_data_i;

  ping_latency_stats_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the host table and registers
  logic [CB-1:0]  sent_tbl [HC];
  logic [CB-1:0]  recv_tbl [HC];
  logic [MW-1:0]  miss_tbl [HC];
  logic [SMW-1:0] sum_tbl  [HC];
  logic [QW-1:0]  sq_tbl   [HC];
  logic           resolve_en;
  logic [MW-1:0]  miss_thr;

  plst_pkg::in_item_t  pending_q [$];
  plst_pkg::out_item_t stats_q [$];
  int        err_count;
  int        cycle_count;
  int        burst_left;
  int        gap_left;
  int        stall_mode;
  int        stall_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic plst_pkg::out_item_t host_stats(plst_pkg::in_item_t it);
    plst_pkg::out_item_t r;
    int                  h;
    logic [CB-1:0]       ns;
    logic [CB-1:0]       n;
    logic [SMW-1:0]      s;
    logic [QW-1:0]       q;
    logic [SMW:0]        s_next;
    logic [QW:0]         q_next;
    logic [39:0]         lat_sq;
    logic [63:0]         mean;
    logic [63:0]         var64;
    logic [63:0]         sd;
    logic [87:0]         a;
    logic [87:0]         b;
    logic [127:0]        quo;
    r = '0;
    r.host_echo = it.host_index;
    h = int'(it.host_index);
    if (it.kind == plst_pkg::KIND_RECORD) begin
      if (sent_tbl[h] != '1) sent_tbl[h] = sent_tbl[h] + 1'b1;
      if (it.answered) begin
        if (recv_tbl[h] != '1) recv_tbl[h] = recv_tbl[h] + 1'b1;
        s_next = {1'b0, sum_tbl[h]} + (SMW+1)'(it.latency_us);
        sum_tbl[h] = s_next[SMW] ? '1 : s_next[SMW-1:0];
        lat_sq = 40'(it.latency_us) * 40'(it.latency_us);
        q_next = {1'b0, sq_tbl[h]} + (QW+1)'(lat_sq);
        sq_tbl[h] = q_next[QW] ? '1 : q_next[QW-1:0];
        miss_tbl[h] = '0;
      end else if (miss_tbl[h] != '1) begin
        miss_tbl[h] = miss_tbl[h] + 1'b1;
      end
      if (resolve_en && miss_tbl[h] >= miss_thr) begin
        miss_tbl[h] = '0;
        r.resolve_request = 1'b1;
      end
    end else begin
      ns = sent_tbl[h];
      n  = recv_tbl[h];
      s  = sum_tbl[h];
      q  = sq_tbl[h];
      sent_tbl[h] = '0;
      recv_tbl[h] = '0;
      sum_tbl[h]  = '0;
      sq_tbl[h]   = '0;
      if (ns != 0) begin
        if (n > ns) n = ns;
        r.has_probes     = 1'b1;
        r.sent_total     = ns;
        r.received_total = n;
        r.drop_rate      = plst_pkg::DROP_W'((64'(ns - n) << plst_pkg::DROP_FRAC)
                                             / 64'(ns));
        if (n != 0) begin
          r.has_replies = 1'b1;
          mean = 64'(s) / 64'(n);
          r.mean_latency = (mean > 64'hFFFFF) ? '1 : mean[OW-1:0];
          if (n >= 2) begin
            a  = 88'(n) * 88'(q);
            b  = 88'(s) * 88'(s);
            sd = '0;
            if (a > b) begin
              quo   = 128'(a - b) / (128'(n) * 128'(n - 1'b1));
              var64 = (quo[127:64] != 0) ? '1 : quo[63:0];
              sd    = int_sqrt(var64);
            end
            r.stddev_latency = (sd > 64'hFFFFF) ? '1 : sd[OW-1:0];
          end
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : sender
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        stats_q.push_back(host_stats(in_data_i));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          in_data_i <= pending_q.pop_front();
          busy = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30)
                                                       : $urandom_range(0, 2);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_valid_i <= busy;
    end
  end

  // receiver: stall pattern switching between modes
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    plst_pkg::out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (stats_q.size() == 0) begin
          flag_mismatch("unexpected item host", out_data_o.host_echo, 0);
        end else begin
          want = stats_q.pop_front();
          if (out_data_o.host_echo != want.host_echo)
            flag_mismatch("host_echo", out_data_o.host_echo, want.host_echo);
          if (out_data_o.resolve_request != want.resolve_request)
            flag_mismatch("resolve_request", out_data_o.resolve_request,
                          want.resolve_request);
          if (out_data_o.has_probes != want.has_probes)
            flag_mismatch("has_probes", out_data_o.has_probes, want.has_probes);
          if (out_data_o.has_replies != want.has_replies)
            flag_mismatch("has_replies", out_data_o.has_replies, want.has_replies);
          if (out_data_o.sent_total != want.sent_total)
            flag_mismatch("sent_total", out_data_o.sent_total, want.sent_total);
          if (out_data_o.received_total != want.received_total)
            flag_mismatch("received_total", out_data_o.received_total,
                          want.received_total);
          if (out_data_o.mean_latency != want.mean_latency)
            flag_mismatch("mean_latency", out_data_o.mean_latency, want.mean_latency);
          if (out_data_o.stddev_latency != want.stddev_latency)
            flag_mismatch("stddev_latency", out_data_o.stddev_latency,
                          want.stddev_latency);
          if (out_data_o.drop_rate != want.drop_rate)
            flag_mismatch("drop_rate", out_data_o.drop_rate, want.drop_rate);
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [IXW-1:0] idx, logic [DTW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == plst_pkg::CFG_RESOLVE_ENABLE) resolve_en = val[0];
    else if (idx == plst_pkg::CFG_MISS_THRESHOLD) miss_thr = val;
  endtask

  task automatic drain();
    forever begin
      @(negedge clk_i);
      if (pending_q.size() == 0 && !in_valid_i && stats_q.size() == 0) break;
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic plst_pkg::in_item_t probe(logic kind, int host, logic ans, int lat);
    plst_pkg::in_item_t it;
    it.kind       = kind;
    it.host_index = plst_pkg::HOST_W'(host);
    it.answered   = ans;
    it.latency_us = plst_pkg::LAT_W'(lat);
    return it;
  endfunction

  task automatic push_random(int count);
    int host;
    int lat;
    for (int i = 0; i < count; i++) begin
      host = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 5) : $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0: lat = $urandom & 32'hFFFFF;
        1: lat = $urandom_range(0, 50);
        default: lat = $urandom_range(100, 5000);
      endcase
      if ($urandom_range(0, 9) == 0)
        pending_q.push_back(probe(plst_pkg::KIND_REPORT, host,
                                  1'($urandom_range(0, 1)), lat));
      else
        pending_q.push_back(probe(plst_pkg::KIND_RECORD, host,
                                  $urandom_range(0, 4) != 0, lat));
    end
  endtask

  initial begin
    for (int i = 0; i < HC; i++) begin
      sent_tbl[i] = '0;
      recv_tbl[i] = '0;
      miss_tbl[i] = '0;
      sum_tbl[i]  = '0;
      sq_tbl[i]   = '0;
    end
    clk_i       = 1'b0;
    resolve_en  = 1'b0;
    miss_thr    = '0;
    err_count   = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(plst_pkg::CFG_RESOLVE_ENABLE, 16'd1);
    write_reg(plst_pkg::CFG_MISS_THRESHOLD, 16'd2);
    pending_q.push_back(probe(plst_pkg::KIND_REPORT, 0, 1'b0, 0));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 1, 1'b1, 0));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 1, 1'b1, 20'hFFFFF));
    pending_q.push_back(probe(plst_pkg::KIND_REPORT, 1, 1'b0, 0));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 2, 1'b1, 1234));
    pending_q.push_back(probe(plst_pkg::KIND_REPORT, 2, 1'b1, 20'hFFFFF));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 3, 1'b0, 20'hFFFFF));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 3, 1'b0, 7));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 3, 1'b0, 0));
    pending_q.push_back(probe(plst_pkg::KIND_REPORT, 3, 1'b0, 0));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 63, 1'b1, 500));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 63, 1'b0, 0));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 63, 1'b1, 700));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 63, 1'b1, 20'hFFFFF));
    pending_q.push_back(probe(plst_pkg::KIND_REPORT, 63, 1'b0, 0));
    pending_q.push_back(probe(plst_pkg::KIND_REPORT, 63, 1'b0, 0));
    push_random(150);
    drain();

    write_reg(plst_pkg::CFG_MISS_THRESHOLD, 16'd0);
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 7, 1'b1, 10));
    pending_q.push_back(probe(plst_pkg::KIND_RECORD, 7, 1'b0, 0));
    pending_q.push_back(probe(plst_pkg::KIND_REPORT, 7, 1'b0, 0));
    push_random(200);
    drain();

    write_reg(plst_pkg::CFG_RESOLVE_ENABLE, 16'd0);
    write_reg(plst_pkg::CFG_MISS_THRESHOLD, 16'd3);
    push_random(200);
    drain();

    write_reg(plst_pkg::CFG_RESOLVE_ENABLE, 16'd1);
    write_reg(plst_pkg::CFG_MISS_THRESHOLD, 16'hFFFF);
    push_random(200);
    drain();

    write_reg(plst_pkg::CFG_MISS_THRESHOLD, 16'd1);
    push_random(250);
    drain();

    repeat (500) @(posedge clk_i);
    if (err_count == 0 && stats_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
